// ----- rtl/mpbp_pkg.sv -----
`default_nettype none
package mpbp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROW_W = 66;
    localparam int QUO_W = 33;
    localparam int CFG_W = 14;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_BEHIND   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_REJECT   = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_COMMIT = 2'd1,
        OP_POINT  = 2'd2,
        OP_BOX    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] corner_a_x;
        logic signed [31:0] corner_a_y;
        logic signed [31:0] corner_a_z;
        logic signed [31:0] corner_b_x;
        logic signed [31:0] corner_b_y;
        logic signed [31:0] corner_b_z;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] x_low;
        logic signed [31:0] y_low;
        logic signed [31:0] x_high;
        logic signed [31:0] y_high;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic       first;
        logic       last;
        logic       is_box;
        logic       coord;
    } t_meta;
endpackage
`default_nettype wire

// ----- rtl/mpbp_front.sv -----
`default_nettype none
module mpbp_front #(
    parameter int FRACTION_BITS = mpbp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire mpbp_pkg::t_in_word                 i_in_word,
    input  wire logic                               i_adv,
    output mpbp_pkg::t_meta                         o_meta,
    output logic signed [mpbp_pkg::ROW_W-1:0]       o_w,
    output logic signed [mpbp_pkg::ROW_W-1:0]       o_x,
    output logic signed [mpbp_pkg::ROW_W-1:0]       o_y
);
    import mpbp_pkg::*;

    localparam longint ONE       = longint'(1) << FRACTION_BITS;
    localparam longint MAG_RAW   = (ONE + 5000) / 10000;
    localparam longint MAG_LIMIT = (MAG_RAW > 0) ? MAG_RAW : 1;
    localparam int     MAG_W     = 36;

    function automatic logic [32:0] abs33(input logic signed [31:0] v);
        logic signed [32:0] e;
        e = {v[31], v};
        return e[32] ? 33'(-e) : 33'(e);
    endfunction

    logic               r_s0_valid;
    t_in_word           r_s0;
    logic [2:0]         r_corner;
    logic signed [31:0] r_stage  [0:15];
    logic signed [31:0] r_active [0:15];
    logic               r_proj_valid;
    logic [MAG_W-1:0]   r_mag;

    t_meta              r_m1;
    logic signed [63:0] r_prod [0:8];
    logic signed [31:0] r_off  [0:2];
    t_meta              r_m2;
    logic signed [ROW_W-1:0] r_row [0:2];

    logic               emit;
    logic               last_corner;
    logic               s0_done;
    logic               mag_ok;
    logic signed [31:0] p [0:2];
    logic [32:0]        abs_new;
    logic [32:0]        abs_old;
    t_meta              m0;
    logic signed [63:0] prod [0:8];
    logic signed [ROW_W-1:0] row_sum [0:2];

    always_comb begin
        emit        = r_s0_valid && i_adv;
        last_corner = (r_s0.operation != OP_BOX) || !r_proj_valid || (r_corner == 3'd7);
        s0_done     = emit && last_corner;
        o_in_stall  = r_s0_valid && !s0_done;
        mag_ok      = r_mag >= MAG_W'(MAG_LIMIT);

        p[0] = r_corner[0] ? r_s0.corner_b_x : r_s0.corner_a_x;
        p[1] = r_corner[1] ? r_s0.corner_b_y : r_s0.corner_a_y;
        p[2] = r_corner[2] ? r_s0.corner_b_z : r_s0.corner_a_z;

        abs_new = abs33(r_s0.entry_value);
        abs_old = abs33(r_stage[r_s0.entry_index]);

        m0.valid  = r_s0_valid;
        m0.status = ST_OK;
        m0.first  = (r_corner == 3'd0);
        m0.last   = last_corner;
        m0.is_box = (r_s0.operation == OP_BOX);
        m0.coord  = 1'b0;
        unique case (r_s0.operation)
            OP_LOAD: begin
                m0.status = ST_OK;
            end
            OP_COMMIT: begin
                m0.status = mag_ok ? ST_OK : ST_REJECT;
            end
            OP_POINT, OP_BOX: begin
                if (!r_proj_valid) begin
                    m0.status = ST_INVALID;
                end else begin
                    m0.coord = 1'b1;
                end
            end
            default: begin
                m0.status = ST_OK;
            end
        endcase

        // rows x, y, w
        for (int j = 0; j < 3; j++) begin
            for (int c = 0; c < 3; c++) begin
                prod[j*3+c] = 64'(r_active[((j == 2) ? 3 : j)*4+c]) * 64'(p[c]);
            end
        end

        for (int j = 0; j < 3; j++) begin
            row_sum[j] = ROW_W'(r_off[j])
                       + ROW_W'(r_prod[j*3+0] >>> FRACTION_BITS)
                       + ROW_W'(r_prod[j*3+1] >>> FRACTION_BITS)
                       + ROW_W'(r_prod[j*3+2] >>> FRACTION_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid   <= 1'b0;
            r_corner     <= 3'd0;
            r_proj_valid <= 1'b0;
            r_mag        <= '0;
            r_m1         <= '0;
            r_m2         <= '0;
            for (int i = 0; i < 16; i++) begin
                r_stage[i]  <= '0;
                r_active[i] <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_s0_valid <= i_in_valid;
            end
            if (s0_done) begin
                r_corner <= 3'd0;
            end else if (emit) begin
                r_corner <= r_corner + 3'd1;
            end
            if (emit) begin
                case (r_s0.operation)
                    OP_LOAD: begin
                        r_stage[r_s0.entry_index] <= r_s0.entry_value;
                        r_mag <= r_mag - MAG_W'(abs_old) + MAG_W'(abs_new);
                    end
                    OP_COMMIT: begin
                        if (mag_ok) begin
                            r_active     <= r_stage;
                            r_proj_valid <= 1'b1;
                        end else begin
                            r_proj_valid <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_adv) begin
                r_m1 <= m0;
                r_m2 <= r_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s0 <= i_in_word;
        end
        if (i_adv) begin
            r_prod   <= prod;
            r_off[0] <= r_active[3];
            r_off[1] <= r_active[7];
            r_off[2] <= r_active[15];
            r_row    <= row_sum;
        end
    end

    assign o_meta = r_m2;
    assign o_x    = r_row[0];
    assign o_y    = r_row[1];
    assign o_w    = r_row[2];
endmodule
`default_nettype wire

// ----- rtl/mpbp_div.sv -----
`default_nettype none
module mpbp_div #(
    parameter int FRACTION_BITS = mpbp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_adv,
    input  wire mpbp_pkg::t_meta                    i_meta,
    input  wire logic signed [mpbp_pkg::ROW_W-1:0]  i_w,
    input  wire logic signed [mpbp_pkg::ROW_W-1:0]  i_x,
    input  wire logic signed [mpbp_pkg::ROW_W-1:0]  i_y,
    output mpbp_pkg::t_meta                         o_meta,
    output logic [mpbp_pkg::QUO_W-1:0]              o_qx,
    output logic [mpbp_pkg::QUO_W-1:0]              o_qy,
    output logic                                    o_sx,
    output logic                                    o_sy
);
    import mpbp_pkg::*;

    localparam int     DIV_W   = ROW_W + QUO_W + 1;
    localparam int     STAGES  = QUO_W;
    localparam int     OVF_SH  = QUO_W - FRACTION_BITS;
    localparam longint ONE     = longint'(1) << FRACTION_BITS;
    localparam longint W_LIMIT = (ONE + 50) / 100;

    t_meta            r_m  [0:STAGES];
    logic [DIV_W-1:0] r_nx [0:STAGES];
    logic [DIV_W-1:0] r_ny [0:STAGES];
    logic [DIV_W-1:0] r_b  [0:STAGES];
    logic [QUO_W-1:0] r_qx [0:STAGES];
    logic [QUO_W-1:0] r_qy [0:STAGES];
    logic             r_sx [0:STAGES];
    logic             r_sy [0:STAGES];

    logic [ROW_W-1:0] ax;
    logic [ROW_W-1:0] ay;
    logic [DIV_W-1:0] bq;
    logic             behind;
    logic             ovf;
    t_meta            m_in;

    always_comb begin
        ax     = i_x[ROW_W-1] ? ROW_W'(-i_x) : ROW_W'(i_x);
        ay     = i_y[ROW_W-1] ? ROW_W'(-i_y) : ROW_W'(i_y);
        bq     = DIV_W'(unsigned'(i_w));
        behind = i_w < $signed(ROW_W'(W_LIMIT));
        ovf    = (DIV_W'(ax) >= (bq << OVF_SH)) || (DIV_W'(ay) >= (bq << OVF_SH));
        m_in   = i_meta;
        if (i_meta.coord && i_meta.status == ST_OK) begin
            if (behind) begin
                m_in.status = ST_BEHIND;
            end else if (ovf) begin
                m_in.status = ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0] <= '0;
        end else if (i_adv) begin
            r_m[0] <= m_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_nx[0] <= DIV_W'(ax) << FRACTION_BITS;
            r_ny[0] <= DIV_W'(ay) << FRACTION_BITS;
            r_b[0]  <= bq;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_sx[0] <= i_x[ROW_W-1];
            r_sy[0] <= i_y[ROW_W-1];
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < STAGES; k++) begin : g_step
        localparam int BI = STAGES - 1 - k;
        logic [DIV_W-1:0] dsh;
        logic             gx;
        logic             gy;
        logic [QUO_W-1:0] qxn;
        logic [QUO_W-1:0] qyn;

        always_comb begin
            dsh     = r_b[k] << BI;
            gx      = r_nx[k] >= dsh;
            gy      = r_ny[k] >= dsh;
            qxn     = r_qx[k];
            qyn     = r_qy[k];
            qxn[BI] = gx;
            qyn[BI] = gy;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m[k+1] <= '0;
            end else if (i_adv) begin
                r_m[k+1] <= r_m[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_nx[k+1] <= gx ? r_nx[k] - dsh : r_nx[k];
                r_ny[k+1] <= gy ? r_ny[k] - dsh : r_ny[k];
                r_b[k+1]  <= r_b[k];
                r_qx[k+1] <= qxn;
                r_qy[k+1] <= qyn;
                r_sx[k+1] <= r_sx[k];
                r_sy[k+1] <= r_sy[k];
            end
        end
    end

    assign o_meta = r_m[STAGES];
    assign o_qx   = r_qx[STAGES];
    assign o_qy   = r_qy[STAGES];
    assign o_sx   = r_sx[STAGES];
    assign o_sy   = r_sy[STAGES];
endmodule
`default_nettype wire

// ----- rtl/mpbp_map.sv -----
`default_nettype none
module mpbp_map #(
    parameter int FRACTION_BITS = mpbp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mpbp_pkg::t_meta                i_meta,
    input  wire logic [mpbp_pkg::QUO_W-1:0]     i_qx,
    input  wire logic [mpbp_pkg::QUO_W-1:0]     i_qy,
    input  wire logic                           i_sx,
    input  wire logic                           i_sy,
    input  wire logic [mpbp_pkg::CFG_W-1:0]     i_width,
    input  wire logic [mpbp_pkg::CFG_W-1:0]     i_height,
    output logic                                o_adv,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output mpbp_pkg::t_out_word                 o_out_word
);
    import mpbp_pkg::*;

    localparam int     T_W = QUO_W + 2;
    localparam int     P_W = T_W + CFG_W + 1;
    localparam longint ONE = longint'(1) << FRACTION_BITS;

    t_meta              r_ma;
    logic signed [T_W-1:0] r_tx;
    logic signed [T_W-1:0] r_ty;
    t_meta              r_mb;
    logic signed [P_W-1:0] r_px;
    logic signed [P_W-1:0] r_py;
    t_meta              r_c;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic [2:0]         r_acc_st;
    logic signed [31:0] r_xl;
    logic signed [31:0] r_yl;
    logic signed [31:0] r_xh;
    logic signed [31:0] r_yh;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic signed [T_W-1:0] one_t;
    logic signed [T_W-1:0] qxs;
    logic signed [T_W-1:0] qys;
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic signed [P_W-1:0] hx;
    logic signed [P_W-1:0] hy;
    logic               fits;
    t_meta              mc;
    logic [2:0]         st;
    logic signed [31:0] xl;
    logic signed [31:0] yl;
    logic signed [31:0] xh;
    logic signed [31:0] yh;
    t_out_word          res;

    always_comb begin
        one_t = T_W'(ONE);
        qxs   = $signed({2'b00, i_qx});
        qys   = $signed({2'b00, i_qy});
        tx    = i_sx ? one_t - qxs : one_t + qxs;
        ty    = i_sy ? one_t + qys : one_t - qys;

        hx   = r_px >>> 1;
        hy   = r_py >>> 1;
        fits = ((hx[P_W-1:31] == '0) || (hx[P_W-1:31] == '1))
            && ((hy[P_W-1:31] == '0) || (hy[P_W-1:31] == '1));
        mc   = r_mb;
        if (r_mb.coord && r_mb.status == ST_OK && !fits) begin
            mc.status = ST_OVERFLOW;
        end

        o_adv = !r_c.valid || !r_c.last || !r_out_valid || !i_out_stall;

        // bounding rectangle, first failing corner wins
        if (r_c.first) begin
            st = r_c.status;
            xl = r_cx;
            xh = r_cx;
            yl = r_cy;
            yh = r_cy;
        end else begin
            st = r_acc_st;
            xl = r_xl;
            xh = r_xh;
            yl = r_yl;
            yh = r_yh;
            if (r_acc_st == ST_OK) begin
                if (r_c.status != ST_OK) begin
                    st = r_c.status;
                end else begin
                    if (r_cx < xl) xl = r_cx;
                    if (r_cx > xh) xh = r_cx;
                    if (r_cy < yl) yl = r_cy;
                    if (r_cy > yh) yh = r_cy;
                end
            end
        end

        res.status = st;
        if (st == ST_OK && r_c.coord && r_c.is_box && (xh <= xl || yh <= yl)) begin
            res.status = ST_EMPTY;
        end
        if (res.status != ST_OK || !r_c.coord) begin
            res.x_low  = '0;
            res.y_low  = '0;
            res.x_high = '0;
            res.y_high = '0;
        end else begin
            res.x_low  = xl;
            res.y_low  = yl;
            res.x_high = xh;
            res.y_high = yh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma        <= '0;
            r_mb        <= '0;
            r_c         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_ma <= i_meta;
                r_mb <= r_ma;
                r_c  <= mc;
            end
            if (o_adv && r_c.valid && r_c.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_tx <= tx;
            r_ty <= ty;
            r_px <= P_W'(r_tx) * P_W'($signed({1'b0, i_width}));
            r_py <= P_W'(r_ty) * P_W'($signed({1'b0, i_height}));
            r_cx <= hx[31:0];
            r_cy <= hy[31:0];
        end
        if (o_adv && r_c.valid) begin
            r_acc_st <= st;
            r_xl     <= xl;
            r_yl     <= yl;
            r_xh     <= xh;
            r_yh     <= yh;
        end
        if (o_adv && r_c.valid && r_c.last) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
endmodule
`default_nettype wire

// ----- rtl/matrix_perspective_box_projector.sv -----
// Load, commit and point words are taken one per cycle when the output
// is not stalled; a box word with a valid matrix holds the input while
// its corners go through the divider, one corner per cycle unless stalled.
// Divider pipeline: 33 stages, one quotient bit per stage for x and y.
// Reset (synchronous, active low) clears the pipeline, the matrices and the
// valid flag; the viewport resets to 1920 x 1080.
`default_nettype none
module matrix_perspective_box_projector #(
    parameter int FRACTION_BITS = mpbp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [mpbp_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire mpbp_pkg::t_in_word             i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output mpbp_pkg::t_out_word                 o_out_word
);
    import mpbp_pkg::*;

    logic [CFG_W-1:0]        r_width;
    logic [CFG_W-1:0]        r_height;
    logic                    adv;
    t_meta                   f_meta;
    t_meta                   d_meta;
    logic signed [ROW_W-1:0] f_w;
    logic signed [ROW_W-1:0] f_x;
    logic signed [ROW_W-1:0] f_y;
    logic [QUO_W-1:0]        d_qx;
    logic [QUO_W-1:0]        d_qy;
    logic                    d_sx;
    logic                    d_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1920);
            r_height <= CFG_W'(1080);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mpbp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_adv      (adv),
        .o_meta     (f_meta),
        .o_w        (f_w),
        .o_x        (f_x),
        .o_y        (f_y)
    );

    mpbp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_meta  (f_meta),
        .i_w     (f_w),
        .i_x     (f_x),
        .i_y     (f_y),
        .o_meta  (d_meta),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_sx    (d_sx),
        .o_sy    (d_sy)
    );

    mpbp_map #(.FRACTION_BITS(FRACTION_BITS)) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_meta      (d_meta),
        .i_qx        (d_qx),
        .i_qy        (d_qy),
        .i_sx        (d_sx),
        .i_sy        (d_sy),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );
endmodule
`default_nettype wire

// ----- rtl/mpbp_check.sv -----
`default_nettype none
module mpbp_check (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire mpbp_pkg::t_out_word         o_out_word
);
    import mpbp_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped under stall");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("result word changed under stall");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |->
            o_out_word.x_low == 0 && o_out_word.y_low == 0 &&
            o_out_word.x_high == 0 && o_out_word.y_high == 0)
        else $error("failed result carries coordinates");

    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_OK |->
            o_out_word.x_high >= o_out_word.x_low &&
            o_out_word.y_high >= o_out_word.y_low)
        else $error("rectangle corners out of order");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");
endmodule

bind matrix_perspective_box_projector mpbp_check u_check (.*);
`default_nettype wire

// ----- verif/tb_matrix_perspective_box_projector.sv -----
`timescale 1ns / 100ps

class proj_scoreboard;
    localparam int     FB      = 16;
    localparam longint ONE     = longint'(1) << FB;
    localparam longint W_LIM   = (ONE + 50) / 100;
    localparam longint MAG_LIM = (ONE + 5000) / 10000;
    localparam longint QLIM    = longint'(1) << (33 - FB);

    logic [31:0] staging[16];
    logic [31:0] active[16];
    bit          proj_ok;
    longint      scr_w;
    longint      scr_h;
    mpbp_pkg::t_out_word expect_q[$];
    int          errors;

    function new();
        foreach (staging[i]) begin
            staging[i] = '0;
            active[i]  = '0;
        end
        proj_ok = 0;
        scr_w   = 1920;
        scr_h   = 1080;
        errors  = 0;
    endfunction

    function void set_viewport(logic idx, logic [13:0] v);
        if (idx == mpbp_pkg::CFG_WIDTH) begin
            scr_w = longint'(v);
        end else begin
            scr_h = longint'(v);
        end
    endfunction

    function longint row_val(int r, longint p[3]);
        longint acc;
        acc = longint'($signed(active[r*4+3]));
        for (int c = 0; c < 3; c++) begin
            acc += (longint'($signed(active[r*4+c])) * p[c]) >>> FB;
        end
        return acc;
    endfunction

    // truncating fixed divide, den > 0; returns 0 on overflow
    function bit fix_div(longint num, longint den, output longint q);
        longint unsigned a, b, ip, rem, frac;
        a = num < 0 ? longint'(-num) : num;
        b = den;
        ip = a / b;
        rem = a % b;
        frac = 0;
        q = 0;
        if (ip >= QLIM) return 0;
        for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= b) begin
                rem -= b;
                frac |= 1;
            end
        end
        q = longint'((ip << FB) | frac);
        if (num < 0) q = -q;
        return 1;
    endfunction

    function logic [2:0] project(longint p[3], output longint sx, output longint sy);
        longint w, x, y, rx, ry;
        sx = 0;
        sy = 0;
        w = row_val(3, p);
        if (w < W_LIM) return mpbp_pkg::ST_BEHIND;
        x = row_val(0, p);
        y = row_val(1, p);
        if (!fix_div(x, w, rx) || !fix_div(y, w, ry)) return mpbp_pkg::ST_OVERFLOW;
        sx = (scr_w * (ONE + rx)) >>> 1;
        sy = (scr_h * (ONE - ry)) >>> 1;
        if (sx < -longint'(64'h8000_0000) || sx > 64'sh7FFF_FFFF ||
            sy < -longint'(64'h8000_0000) || sy > 64'sh7FFF_FFFF) begin
            return mpbp_pkg::ST_OVERFLOW;
        end
        return mpbp_pkg::ST_OK;
    endfunction

    function void note_input(mpbp_pkg::t_in_word w);
        mpbp_pkg::t_out_word e;
        longint unsigned mag;
        longint v, sx, sy, xl, yl, xh, yh;
        longint a[3], b[3], p[3];
        e = '0;
        e.status = mpbp_pkg::ST_OK;
        xl = 0; yl = 0; xh = 0; yh = 0;
        a[0] = w.corner_a_x; a[1] = w.corner_a_y; a[2] = w.corner_a_z;
        b[0] = w.corner_b_x; b[1] = w.corner_b_y; b[2] = w.corner_b_z;
        case (w.operation)
            mpbp_pkg::OP_LOAD: begin
                staging[w.entry_index] = w.entry_value;
            end
            mpbp_pkg::OP_COMMIT: begin
                mag = 0;
                foreach (staging[i]) begin
                    v = longint'($signed(staging[i]));
                    mag += v < 0 ? -v : v;
                end
                if (mag >= MAG_LIM) begin
                    active = staging;
                    proj_ok = 1;
                end else begin
                    proj_ok = 0;
                    e.status = mpbp_pkg::ST_REJECT;
                end
            end
            default: begin
                if (!proj_ok) begin
                    e.status = mpbp_pkg::ST_INVALID;
                end else if (w.operation == mpbp_pkg::OP_POINT) begin
                    e.status = project(a, sx, sy);
                    xl = sx; xh = sx; yl = sy; yh = sy;
                end else begin
                    for (int c = 0; c < 8; c++) begin
                        for (int i = 0; i < 3; i++) p[i] = c[i] ? b[i] : a[i];
                        e.status = project(p, sx, sy);
                        if (e.status != mpbp_pkg::ST_OK) break;
                        if (c == 0 || sx < xl) xl = sx;
                        if (c == 0 || sy < yl) yl = sy;
                        if (c == 0 || sx > xh) xh = sx;
                        if (c == 0 || sy > yh) yh = sy;
                    end
                    if (e.status == mpbp_pkg::ST_OK && (xh <= xl || yh <= yl))
                        e.status = mpbp_pkg::ST_EMPTY;
                end
                if (e.status == mpbp_pkg::ST_OK) begin
                    e.x_low = xl[31:0]; e.y_low = yl[31:0];
                    e.x_high = xh[31:0]; e.y_high = yh[31:0];
                end
            end
        endcase
        expect_q.push_back(e);
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    task check(mpbp_pkg::t_out_word g);
        mpbp_pkg::t_out_word e;
        if (expect_q.size() == 0) begin
            report("result word with nothing expected");
            return;
        end
        e = expect_q.pop_front();
        if (g.status !== e.status)
            report($sformatf("status got %0d exp %0d", g.status, e.status));
        if (g.x_low !== e.x_low)
            report($sformatf("x_low got %h exp %h", g.x_low, e.x_low));
        if (g.y_low !== e.y_low)
            report($sformatf("y_low got %h exp %h", g.y_low, e.y_low));
        if (g.x_high !== e.x_high)
            report($sformatf("x_high got %h exp %h", g.x_high, e.x_high));
        if (g.y_high !== e.y_high)
            report($sformatf("y_high got %h exp %h", g.y_high, e.y_high));
    endtask
endclass

module tb_matrix_perspective_box_projector;
    import mpbp_pkg::*;

    localparam int ONE        = 1 << 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN      = 60;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_word            i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_word           o_out_word;

    proj_scoreboard sb;
    int  items;
    int  results;
    int  idle_cycles;
    bit  done;

    matrix_perspective_box_projector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check(o_out_word);
            results++;
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_matrix_perspective_box_projector NOT OK");
            $finish;
        end
    end

    // receiver: short and long stalls, one very long hold to back up the pipe
    initial begin
        bit held;
        bit val;
        int n;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            if (!held && results >= 150) begin
                held = 1;
                val = 1;
                n = 400;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin val = 0; n = $urandom_range(1, 30); end
                    6, 7, 8:          begin val = 1; n = $urandom_range(1, 3); end
                    default:          begin val = 1; n = $urandom_range(10, 60); end
                endcase
            end
            @(negedge i_clk);
            i_out_stall <= val;
            repeat (n - 1) @(negedge i_clk);
        end
    end

    function automatic t_in_word mk(t_op op, logic [3:0] idx, logic [31:0] val,
                                    logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        t_in_word w;
        w.operation = op;
        w.entry_index = idx;
        w.entry_value = val;
        w.corner_a_x = ax; w.corner_a_y = ay; w.corner_a_z = az;
        w.corner_b_x = bx; w.corner_b_y = by; w.corner_b_z = bz;
        return w;
    endfunction

    function automatic logic [31:0] rnd_coord(bit depth);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 2))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    default: return 32'h0;
                endcase
            end
            default: begin
                if (depth) return $urandom_range(ONE / 4, 50 * ONE);
                return $urandom_range(0, 20 * ONE) - 10 * ONE;
            end
        endcase
    endfunction

    function automatic logic [31:0] rnd_entry(int idx, bit tiny);
        if (tiny) return idx == 15 ? $urandom_range(0, 9) : 0;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: begin
                if (idx == 0 || idx == 5 || idx == 14) return $urandom_range(ONE / 2, 2 * ONE);
                return $urandom_range(0, ONE / 2) - ONE / 4;
            end
        endcase
    endfunction

    task send_word(t_in_word w);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        items++;
        case ($urandom_range(0, 19))
            0:                  gap = $urandom_range(10, 40);
            1, 2, 3, 4, 5:      gap = $urandom_range(1, 3);
            default:            gap = 0;
        endcase
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task write_viewport(logic [13:0] w, logic [13:0] h);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_viewport(CFG_WIDTH, w);
        sb.set_viewport(CFG_HEIGHT, h);
    endtask

    task send_box_or_point();
        logic [31:0] ax, ay, az, bx, by, bz;
        ax = rnd_coord(0); ay = rnd_coord(0); az = rnd_coord(1);
        if ($urandom_range(0, 4) == 0) begin
            bx = rnd_coord(0); by = rnd_coord(0); bz = rnd_coord(1);
        end else begin
            bx = ax + $urandom_range(0, 4 * ONE);
            by = ay + $urandom_range(0, 4 * ONE);
            bz = az + $urandom_range(0, 4 * ONE);
        end
        send_word(mk($urandom_range(0, 8) < 4 ? OP_POINT : OP_BOX,
                     $urandom, $urandom, ax, ay, az, bx, by, bz));
    endtask

    task run_scene(bit reload);
        bit tiny;
        int k;
        if (reload) begin
            tiny = $urandom_range(0, 7) == 0;
            for (int i = 0; i < 16; i++)
                send_word(mk(OP_LOAD, i, rnd_entry(i, tiny), $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom));
            send_word(mk(OP_COMMIT, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom));
        end else if ($urandom_range(0, 9) == 0) begin
            send_word(mk($urandom_range(0, 1) ? OP_LOAD : OP_COMMIT, $urandom,
                         rnd_entry($urandom_range(0, 15), 0), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom));
        end
        k = $urandom_range(3, 12);
        repeat (k) send_box_or_point();
    endtask

    initial begin
        logic [13:0] vw[5];
        logic [13:0] vh[5];
        sb = new();
        items = 0;
        results = 0;
        idle_cycles = 0;
        done = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no matrix committed yet
        send_word(mk(OP_POINT, 0, 0, 0, 0, ONE, 0, 0, 0));
        send_word(mk(OP_BOX, 0, 0, -ONE, -ONE, ONE, ONE, ONE, 2 * ONE));
        // magnitude just under threshold: rejected
        for (int i = 0; i < 16; i++)
            send_word(mk(OP_LOAD, i, i == 15 ? 6 : 0, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_POINT, 0, 0, 0, 0, ONE, 0, 0, 0));
        send_word(mk(OP_LOAD, 0, ONE, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_LOAD, 5, ONE, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_LOAD, 14, ONE, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_COMMIT, 4'hF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_POINT, 0, 0, 0, 0, ONE, 0, 0, 0));
        send_word(mk(OP_POINT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
        send_word(mk(OP_BOX, 0, 0, -ONE, -ONE, 2 * ONE, ONE, ONE, 4 * ONE));
        // unordered corners
        send_word(mk(OP_BOX, 0, 0, ONE, ONE, 4 * ONE, -ONE, -ONE, 2 * ONE));
        // four corners behind the camera
        send_word(mk(OP_BOX, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, 2 * ONE));
        // degenerate box
        send_word(mk(OP_BOX, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE));
        // divide overflow
        send_word(mk(OP_POINT, 0, 0, 32'h7FFF_FFFF, 0, 1000, 0, 0, 0));
        send_word(mk(OP_BOX, 0, 0, 0, 0, 1000, 32'h7FFF_FFFF, ONE, 2000));

        vw[0] = 14'd1920; vh[0] = 14'd1080;
        vw[1] = 14'd8192; vh[1] = 14'd8192;
        vw[2] = 14'd1;    vh[2] = 14'd1;
        vw[3] = 14'd0;    vh[3] = 14'h3FFF;
        vw[4] = $urandom_range(1, 8192); vh[4] = $urandom_range(1, 8192);
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                drain();
                write_viewport(vw[ph], vh[ph]);
            end
            run_scene(1);
            while (items < (ph + 1) * 170) run_scene($urandom_range(0, 5) == 0);
        end
        drain();
        done = 1;
        if (sb.errors == 0) begin
            $display("tb_matrix_perspective_box_projector OK");
        end else begin
            $display("tb_matrix_perspective_box_projector NOT OK");
        end
        $finish;
    end
endmodule
